// ----- hdl/ata_seq_pkg.sv -----
// ----------------------------------------------------------------------------
// ata_seq_pkg
// Shared types and codes for the ATA PIO LBA28 sector sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ata_seq_pkg;

  // Input command codes
  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_STATUS  = 2'd1;
  localparam logic [1:0] CMD_DATA    = 2'd2;

  // Sequencer phases
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_WBSY1  = 4'd1;
  localparam logic [3:0] PH_WBSY2  = 4'd2;
  localparam logic [3:0] PH_WDRDY  = 4'd3;
  localparam logic [3:0] PH_WBSY3  = 4'd4;
  localparam logic [3:0] PH_CHKERR = 4'd5;
  localparam logic [3:0] PH_WDRQ   = 4'd6;
  localparam logic [3:0] PH_RDATA  = 4'd7;
  localparam logic [3:0] PH_WHOST  = 4'd8;

  // Result actions
  localparam logic [2:0] ACT_RSTAT = 3'd0;
  localparam logic [2:0] ACT_WREG  = 3'd1;
  localparam logic [2:0] ACT_RDATA = 3'd2;
  localparam logic [2:0] ACT_WDATA = 3'd3;
  localparam logic [2:0] ACT_HOST  = 3'd4;
  localparam logic [2:0] ACT_WANT  = 3'd5;
  localparam logic [2:0] ACT_DONE  = 3'd6;

  // Outcomes
  localparam logic [1:0] OC_OK      = 2'd0;
  localparam logic [1:0] OC_TIMEOUT = 2'd1;
  localparam logic [1:0] OC_DEVERR  = 2'd2;
  localparam logic [1:0] OC_UNEXP   = 2'd3;

  // Configuration register indexes
  localparam logic [3:0] CFG_POLL_LIMIT = 4'd0;
  localparam logic [3:0] CFG_CHANNEL    = 4'd1;

  // Channel bases and task-file register offsets
  localparam logic [9:0] BASE_PRIMARY   = 10'h1F0;
  localparam logic [9:0] BASE_SECONDARY = 10'h170;
  localparam logic [9:0] OFS_DATA    = 10'd0;
  localparam logic [9:0] OFS_SECCNT  = 10'd2;
  localparam logic [9:0] OFS_LBA_LO  = 10'd3;
  localparam logic [9:0] OFS_LBA_MID = 10'd4;
  localparam logic [9:0] OFS_LBA_HI  = 10'd5;
  localparam logic [9:0] OFS_DRVHEAD = 10'd6;
  localparam logic [9:0] OFS_CMDSTAT = 10'd7;

  localparam logic [7:0] DRVHEAD_LBA      = 8'hE0;  // 0xA0 | 0x40
  localparam logic [7:0] OPC_READ_SECTOR  = 8'h20;
  localparam logic [7:0] OPC_WRITE_SECTOR = 8'h30;

  // Status bits
  localparam int ST_BSY  = 7;
  localparam int ST_DRDY = 6;
  localparam int ST_DRQ  = 3;
  localparam int ST_ERR  = 0;

  localparam int MAX_RESULTS = 6;

  typedef struct packed {
    logic [2:0]  action;
    logic [9:0]  port;
    logic [15:0] value;
    logic [1:0]  outcome;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] item;
    logic [2:0]                count;   // 1..MAX_RESULTS
  } batch_t;

  typedef struct packed {
    logic [15:0] poll_limit;
    logic        channel_select;
  } cfg_t;

  function automatic result_t mk_result(logic [2:0] act, logic [9:0] prt,
                                        logic [15:0] val, logic [1:0] oc);
    result_t r;
    r.action  = act;
    r.port    = prt;
    r.value   = val;
    r.outcome = oc;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ata_seq_core.sv -----
// ----------------------------------------------------------------------------
// ata_seq_core
// Sequencer state and per-transaction result batch generation.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_seq_core #(
  parameter int WORDS_PER_SECTOR = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ata_seq_pkg::cfg_t   cfg,
  input  wire logic                accept,
  input  wire logic [1:0]          command,
  input  wire logic                drive,
  input  wire logic                write_op,
  input  wire logic [27:0]         lba,
  input  wire logic [7:0]          status_byte,
  input  wire logic [15:0]         data_word,
  output ata_seq_pkg::batch_t      batch
);
  import ata_seq_pkg::*;

  localparam int WCW = $clog2(WORDS_PER_SECTOR + 1);
  localparam logic [WCW-1:0] WPS = WCW'(WORDS_PER_SECTOR);

  logic [3:0]     phase, phase_next;
  logic [15:0]    poll_count, poll_count_next;
  logic [WCW-1:0] word_count, word_count_next;
  logic           held_drive, held_write;
  logic [27:0]    held_lba;
  logic           latch_req;

  logic [9:0]  base;
  logic [9:0]  stat_port;
  logic [15:0] lim;
  logic [15:0] swapped;
  logic [WCW-1:0] wc_inc;
  logic        met;
  result_t     rstat;
  result_t     unexp;

  always_comb begin
    base      = cfg.channel_select ? BASE_SECONDARY : BASE_PRIMARY;
    stat_port = base + OFS_CMDSTAT;
    lim       = (cfg.poll_limit == 16'd0) ? 16'd1 : cfg.poll_limit;
    swapped   = {data_word[7:0], data_word[15:8]};
    wc_inc    = word_count + WCW'(1);
    rstat     = mk_result(ACT_RSTAT, stat_port, 16'd0, OC_OK);
    unexp     = mk_result(ACT_DONE, 10'd0, 16'd0, OC_UNEXP);
    case (phase)
      PH_WDRDY: met = status_byte[ST_DRDY];
      PH_WDRQ:  met = status_byte[ST_DRQ];
      default:  met = !status_byte[ST_BSY];
    endcase
  end

  always_comb begin
    phase_next      = phase;
    poll_count_next = poll_count;
    word_count_next = word_count;
    latch_req       = 1'b0;
    batch           = '0;
    batch.count     = 3'd1;
    batch.item[0]   = unexp;

    if (phase == PH_IDLE || phase > PH_WHOST) begin
      if (command == CMD_REQUEST) begin
        latch_req       = 1'b1;
        word_count_next = '0;
        batch.item[0]   = rstat;
        poll_count_next = 16'd1;
        phase_next      = PH_WBSY1;
      end else begin
        phase_next = PH_IDLE;
      end
    end else if (phase == PH_RDATA || phase == PH_WHOST) begin
      if (command != CMD_DATA) begin
        phase_next = PH_IDLE;
      end else begin
        batch.count = 3'd2;
        if (phase == PH_RDATA) begin
          batch.item[0] = mk_result(ACT_HOST, 10'd0, swapped, OC_OK);
        end else begin
          batch.item[0] = mk_result(ACT_WDATA, base + OFS_DATA, swapped, OC_OK);
        end
        word_count_next = wc_inc;
        if (wc_inc >= WPS) begin
          batch.item[1] = mk_result(ACT_DONE, 10'd0, 16'd0, OC_OK);
          phase_next    = PH_IDLE;
        end else if (phase == PH_RDATA) begin
          batch.item[1] = mk_result(ACT_RDATA, base + OFS_DATA, 16'd0, OC_OK);
        end else begin
          batch.item[1] = mk_result(ACT_WANT, 10'd0, 16'd0, OC_OK);
        end
      end
    end else if (command != CMD_STATUS) begin
      phase_next = PH_IDLE;
    end else if (phase == PH_CHKERR) begin
      if (status_byte[ST_ERR]) begin
        batch.item[0] = mk_result(ACT_DONE, 10'd0, 16'd0, OC_DEVERR);
        phase_next    = PH_IDLE;
      end else begin
        batch.item[0]   = rstat;
        poll_count_next = 16'd1;
        phase_next      = PH_WDRQ;
      end
    end else if (!met) begin
      if (poll_count >= lim) begin
        batch.item[0] = mk_result(ACT_DONE, 10'd0, 16'd0, OC_TIMEOUT);
        phase_next    = PH_IDLE;
      end else begin
        batch.item[0]   = rstat;
        poll_count_next = poll_count + 16'd1;
      end
    end else begin
      case (phase)
        PH_WBSY1: begin
          batch.count     = 3'd2;
          batch.item[0]   = mk_result(ACT_WREG, base + OFS_DRVHEAD,
                              {8'd0, DRVHEAD_LBA | {3'd0, held_drive, held_lba[27:24]}},
                              OC_OK);
          batch.item[1]   = rstat;
          poll_count_next = 16'd1;
          phase_next      = PH_WBSY2;
        end
        PH_WBSY2: begin
          batch.item[0]   = rstat;
          poll_count_next = 16'd1;
          phase_next      = PH_WDRDY;
        end
        PH_WDRDY: begin
          batch.count     = 3'd6;
          batch.item[0]   = mk_result(ACT_WREG, base + OFS_SECCNT, 16'd1, OC_OK);
          batch.item[1]   = mk_result(ACT_WREG, base + OFS_LBA_LO,
                                      {8'd0, held_lba[7:0]}, OC_OK);
          batch.item[2]   = mk_result(ACT_WREG, base + OFS_LBA_MID,
                                      {8'd0, held_lba[15:8]}, OC_OK);
          batch.item[3]   = mk_result(ACT_WREG, base + OFS_LBA_HI,
                                      {8'd0, held_lba[23:16]}, OC_OK);
          batch.item[4]   = mk_result(ACT_WREG, stat_port,
                                      {8'd0, held_write ? OPC_WRITE_SECTOR
                                                        : OPC_READ_SECTOR}, OC_OK);
          batch.item[5]   = rstat;
          poll_count_next = 16'd1;
          phase_next      = PH_WBSY3;
        end
        PH_WBSY3: begin
          batch.item[0] = rstat;
          phase_next    = PH_CHKERR;
        end
        default: begin  // DRQ seen
          word_count_next = '0;
          if (held_write) begin
            batch.item[0] = mk_result(ACT_WANT, 10'd0, 16'd0, OC_OK);
            phase_next    = PH_WHOST;
          end else begin
            batch.item[0] = mk_result(ACT_RDATA, base + OFS_DATA, 16'd0, OC_OK);
            phase_next    = PH_RDATA;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      poll_count <= '0;
      word_count <= '0;
      held_drive <= 1'b0;
      held_write <= 1'b0;
      held_lba   <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      poll_count <= poll_count_next;
      word_count <= word_count_next;
      if (latch_req) begin
        held_drive <= drive;
        held_write <= write_op;
        held_lba   <= lba;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ata_seq_emit.sv -----
// ----------------------------------------------------------------------------
// ata_seq_emit
// Result batch register; hands out one result per output transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_seq_emit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire ata_seq_pkg::batch_t batch_in,
  output logic                     can_load,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [31:0]              m_tdata,
  output logic [2:0]               m_tuser,
  output logic                     m_tlast
);
  import ata_seq_pkg::*;

  result_t     item [MAX_RESULTS];
  logic [2:0]  count;
  logic [2:0]  idx;
  logic        busy;
  logic        at_last;
  result_t     cur;

  always_comb begin
    at_last  = (idx == count - 3'd1);
    cur      = item[idx];
    m_tvalid = busy;
    m_tuser  = cur.action;
    m_tdata  = {4'd0, cur.outcome, cur.value, cur.port};
    m_tlast  = at_last;
    can_load = !busy || (m_tready && at_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && m_tready) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      count <= batch_in.count;
      for (int i = 0; i < MAX_RESULTS; i++) begin
        item[i] <= batch_in.item[i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ata_pio_sector_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// ata_pio_sector_sequencer_top
// Host-side ATA PIO single-sector LBA28 read/write sequencer.
// ----------------------------------------------------------------------------
// The first result of an input transaction is valid in the cycle after it is
// accepted; an item yields 1 to 6 results, one per cycle while m_tready is high.
// Throughput: one input per cycle while each yields one result (m_tready high);
// an item with N results holds the input until the batch register drains.
// Reset: synchronous rst returns the sequencer to idle, empties the output,
// and loads poll_limit = 1000 and channel_select = 0.
`default_nettype none

module ata_pio_sector_sequencer_top #(
  parameter int WORDS_PER_SECTOR = 256   // data words per sector, 1..256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata, low bit up: drive[0], write_op[1], lba[29:2], status_byte[37:30],
  // data_word[53:38], zero pad[55:54]
  input  wire logic [55:0] s_tdata,
  // s_tuser: command[1:0]
  input  wire logic [1:0]  s_tuser,
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata, low bit up: port[9:0], bus_value[25:10], outcome[27:26], pad[31:28]
  output logic [31:0]      m_tdata,
  // m_tuser: action[2:0]
  output logic [2:0]       m_tuser,
  output logic             m_tlast,    // last result of this input transaction
  // Configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import ata_seq_pkg::*;

  cfg_t   cfg;
  batch_t batch;
  logic   can_load;
  logic   accept;

  // Config registers are always writable; writes to unknown indexes drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_limit     <= 16'd1000;
      cfg.channel_select <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POLL_LIMIT: cfg.poll_limit     <= cfg_data;
        CFG_CHANNEL:    cfg.channel_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input is taken when the batch register is empty or drains this cycle,
  // so a single-result item streams straight through.
  assign s_tready = can_load;
  assign accept   = s_tvalid && s_tready;

  ata_seq_core #(
    .WORDS_PER_SECTOR(WORDS_PER_SECTOR)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .command    (s_tuser),
    .drive      (s_tdata[0]),
    .write_op   (s_tdata[1]),
    .lba        (s_tdata[29:2]),
    .status_byte(s_tdata[37:30]),
    .data_word  (s_tdata[53:38]),
    .batch      (batch)
  );

  ata_seq_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .batch_in(batch),
    .can_load(can_load),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  // An input transaction may only overlap the final result of the prior batch.
  a_accept_on_last: assert property (@(posedge clk) disable iff (rst)
    (accept && m_tvalid) |-> (m_tready && m_tlast))
    else $error("input accepted while results still pending");

  // A finished result always closes its batch.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ACT_DONE) |-> m_tlast)
    else $error("finished result not marked last");

  // Only finished results carry a nonzero outcome.
  a_outcome_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ACT_DONE) |-> (m_tdata[27:26] == OC_OK))
    else $error("outcome set on non-finished result");

  // An accepted item always produces a result in the next cycle.
  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted item produced no result");

endmodule

`default_nettype wire
